[hw/rtl/encoder_positioned_lift_drive_core_macros.svh]
// Assertion macros shared by the lift drive RTL.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef ENCODER_POSITIONED_LIFT_DRIVE_CORE_MACROS_SVH
`define ENCODER_POSITIONED_LIFT_DRIVE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EPLD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EPLD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/epld_pkg.sv]
// Types, constants and helper functions for the lift drive core.
// No dependencies; every other RTL file except the assertion macros header imports this package.
package epld_pkg;

  // Field widths.
  localparam int COUNT_WIDTH = 16;
  localparam int OP_W        = 3;
  localparam int DUTY_W      = 8;
  localparam int FOOD_W      = 12;
  localparam int POS_W       = 16;
  localparam int THR_W       = 11;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_RAISE   = 3'd0;
  localparam logic [OP_W-1:0] OP_LOWER   = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd2;
  localparam logic [OP_W-1:0] OP_LIMIT   = 3'd3;
  localparam logic [OP_W-1:0] OP_ENCODER = 3'd4;

  // Quadrature transitions as {new phase, old phase}.
  localparam logic [3:0] ENC_UP_A = 4'b0001;
  localparam logic [3:0] ENC_UP_B = 4'b0111;
  localparam logic [3:0] ENC_UP_C = 4'b1000;
  localparam logic [3:0] ENC_UP_D = 4'b1110;
  localparam logic [3:0] ENC_DN_A = 4'b0010;
  localparam logic [3:0] ENC_DN_B = 4'b0100;
  localparam logic [3:0] ENC_DN_C = 4'b1011;
  localparam logic [3:0] ENC_DN_D = 4'b1101;

  // Pulse distance 0.40906 mm in Q16, and the fixed-point stop geometry.
  localparam int PULSE_Q16     = 26808;
  localparam int PULSE_SHIFT   = 3;
  localparam int PULSE_RED     = PULSE_Q16 >> PULSE_SHIFT;
  localparam int HEIGHT_SHIFT  = 12 - PULSE_SHIFT;
  localparam int PARTIAL_MM    = 41;
  localparam int PARTIAL_TICKS = 7;
  localparam int PARTIAL_THR   = ((PARTIAL_MM << 16) + PULSE_Q16 - 1) / PULSE_Q16
                                 - PARTIAL_TICKS;
  localparam int FIXED_SWEEP   = 225;
  localparam logic [FOOD_W-1:0] FOOD_RESET = 12'd184;

  // Stopping ticks by stack height (Q4 millimetres).
  localparam logic [FOOD_W-1:0] FOOD_MID  = 12'd80;
  localparam logic [FOOD_W-1:0] FOOD_HIGH = 12'd192;
  localparam logic [3:0] TICKS_LOW  = 4'd7;
  localparam logic [3:0] TICKS_MID  = 4'd10;
  localparam logic [3:0] TICKS_HIGH = 4'd14;

  // Reciprocal divide by PULSE_RED, exact for every dividend below 2**DIV_N.
  localparam int DIV_N   = FOOD_W + HEIGHT_SHIFT + 1;
  localparam int DIV_L   = $clog2(PULSE_RED);
  localparam int DIV_K   = DIV_N + DIV_L;
  localparam longint RECIP_M = ((longint'(1) << DIV_K) + PULSE_RED - 1) / PULSE_RED;
  localparam int RECIP_W = $clog2(RECIP_M + 1);
  localparam int PROD_W  = DIV_N + RECIP_W;
  localparam int QUOT_W  = THR_W - 1;

  // Count saturation limits.
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
  localparam int PW    = (COUNT_WIDTH > POS_W) ? COUNT_WIDTH : POS_W;
  localparam int POS_MAX = 32767;
  localparam int POS_MIN = -32768;

  // One input transaction.
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [DUTY_W-1:0] duty;
    logic              retract_after;
    logic              partial_raise;
    logic              switch_level;
    logic              enc_a;
    logic              enc_b;
  } epld_item_t;

  // Architectural state of the drive.
  typedef struct packed {
    logic signed [COUNT_WIDTH-1:0] count;
    logic [1:0]                    last_phase;
    logic                          going_up;
    logic                          halted;
    logic                          retract_on_lower;
    logic                          retract_on_raise;
    logic                          partial_armed;
    logic [DUTY_W-1:0]             up_duty;
    logic [DUTY_W-1:0]             down_duty;
  } epld_state_t;

  // One result transaction.
  typedef struct packed {
    logic [DUTY_W-1:0]       up_drive;
    logic [DUTY_W-1:0]       down_drive;
    logic                    moving;
    logic signed [POS_W-1:0] position;
    logic                    sweep_serving;
    logic                    sweep_fixed;
  } epld_res_t;

  // Lowering stop threshold: ticks - ceil(food * 4096 / PULSE_Q16).
  function automatic logic signed [THR_W-1:0] epld_lower_thr(input logic [FOOD_W-1:0] food);
    logic [DIV_N-1:0]  dividend;
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;
    logic [3:0]        ticks;
    dividend = DIV_N'({food, {HEIGHT_SHIFT{1'b0}}}) + DIV_N'(PULSE_RED - 1);
    prod     = PROD_W'(dividend) * PROD_W'(RECIP_M);
    quot     = prod[DIV_K +: QUOT_W];
    ticks    = TICKS_LOW;
    if (food > FOOD_MID) ticks = TICKS_MID;
    if (food > FOOD_HIGH) ticks = TICKS_HIGH;
    return $signed(THR_W'(ticks)) - $signed({1'b0, quot});
  endfunction

  localparam logic signed [THR_W-1:0] LOWER_THR_RESET = epld_lower_thr(FOOD_RESET);

endpackage

[hw/rtl/epld_if.sv]
// Valid/ready channel interfaces for the lift drive core.
// Depends on epld_pkg for field widths.
interface epld_in_if;
  import epld_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DUTY_W-1:0] duty;
  logic              retract_after;
  logic              partial_raise;
  logic              switch_level;
  logic              enc_a;
  logic              enc_b;
  modport source(output valid, operation, duty, retract_after, partial_raise,
                 switch_level, enc_a, enc_b, input ready);
  modport sink(input valid, operation, duty, retract_after, partial_raise,
               switch_level, enc_a, enc_b, output ready);
endinterface

interface epld_out_if;
  import epld_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [DUTY_W-1:0]       up_drive;
  logic [DUTY_W-1:0]       down_drive;
  logic                    moving;
  logic signed [POS_W-1:0] position;
  logic                    sweep_serving;
  logic                    sweep_fixed;
  modport source(output valid, up_drive, down_drive, moving, position, sweep_serving,
                 sweep_fixed, input ready);
  modport sink(input valid, up_drive, down_drive, moving, position, sweep_serving,
               sweep_fixed, output ready);
endinterface

interface epld_cfg_if;
  import epld_pkg::*;
  logic              valid;
  logic              ready;
  logic [FOOD_W-1:0] food_height;
  modport source(output valid, food_height, input ready);
  modport sink(input valid, food_height, output ready);
endinterface

[hw/rtl/epld_step.sv]
// Next-state logic of the lift drive for one event transaction.
// Depends on epld_pkg; purely combinational.
module epld_step (
  input  epld_pkg::epld_state_t             state,
  input  epld_pkg::epld_item_t              item,
  input  logic signed [epld_pkg::THR_W-1:0] lower_thr,
  output epld_pkg::epld_state_t             state_nxt,
  output epld_pkg::epld_res_t               res
);
  import epld_pkg::*;

  epld_state_t             st;
  logic                    pulse_serving;
  logic                    pulse_fixed;
  logic                    do_halt;
  logic [1:0]              phase;
  logic [3:0]              trans;
  logic signed [COUNT_WIDTH-1:0] cnt_enc;
  logic signed [CMP_W-1:0] cnt_ext;
  logic signed [CMP_W-1:0] thr_ext;
  logic signed [CMP_W-1:0] part_ext;
  logic signed [PW-1:0]    pos_ext;

  // Encoder decode with saturating count.
  always_comb begin
    phase   = {item.enc_a, item.enc_b};
    trans   = {phase, state.last_phase};
    cnt_enc = state.count;
    case (trans) inside
      ENC_UP_A, ENC_UP_B, ENC_UP_C, ENC_UP_D: begin
        if (state.count != CNT_MAX) cnt_enc = state.count + COUNT_WIDTH'(1);
      end
      ENC_DN_A, ENC_DN_B, ENC_DN_C, ENC_DN_D: begin
        if (state.count != CNT_MIN) cnt_enc = state.count - COUNT_WIDTH'(1);
      end
      default: cnt_enc = state.count;
    endcase
    cnt_ext  = CMP_W'(cnt_enc);
    thr_ext  = CMP_W'(lower_thr);
    part_ext = CMP_W'(PARTIAL_THR);
  end

  // Event handling; a halt is applied after the event's own updates.
  always_comb begin
    st            = state;
    do_halt       = 1'b0;
    pulse_serving = 1'b0;
    pulse_fixed   = 1'b0;
    case (item.operation)
      OP_RAISE: begin
        if (item.switch_level) begin
          st.count            = '0;
          st.going_up         = 1'b1;
          st.halted           = 1'b0;
          st.retract_on_raise = item.retract_after;
          st.partial_armed    = item.partial_raise;
          st.up_duty          = item.duty;
          st.down_duty        = '0;
        end
      end
      OP_LOWER: begin
        st.count            = '0;
        st.halted           = 1'b0;
        st.going_up         = 1'b0;
        st.partial_armed    = 1'b0;
        st.retract_on_lower = item.retract_after;
        st.up_duty          = '0;
        st.down_duty        = item.duty;
      end
      OP_STOP: do_halt = 1'b1;
      OP_LIMIT: do_halt = state.going_up;
      OP_ENCODER: begin
        st.count      = cnt_enc;
        st.last_phase = phase;
        if (!state.going_up && !state.halted && (cnt_ext <= thr_ext)) begin
          do_halt = 1'b1;
        end else if (state.partial_armed && !state.halted && (cnt_ext >= part_ext)) begin
          do_halt          = 1'b1;
          st.partial_armed = 1'b0;
        end
      end
      default: st = state;
    endcase
    if (do_halt) begin
      st.up_duty   = '0;
      st.down_duty = '0;
      st.going_up  = 1'b0;
      st.halted    = 1'b1;
      pulse_serving       = st.retract_on_lower;
      pulse_fixed         = st.retract_on_raise;
      st.retract_on_lower = 1'b0;
      st.retract_on_raise = 1'b0;
    end
  end

  // Result view of the new state, position clamped to 16 signed bits.
  always_comb begin
    pos_ext = PW'(st.count);
    if (pos_ext > $signed(PW'(POS_MAX))) begin
      res.position = POS_W'(POS_MAX);
    end else if (pos_ext < $signed(PW'(POS_MIN))) begin
      res.position = POS_W'(POS_MIN);
    end else begin
      res.position = pos_ext[POS_W-1:0];
    end
    res.up_drive      = st.up_duty;
    res.down_drive    = st.down_duty;
    res.moving        = !st.halted;
    res.sweep_serving = pulse_serving;
    res.sweep_fixed   = pulse_fixed;
  end

  assign state_nxt = st;

endmodule

[hw/rtl/encoder_positioned_lift_drive_core.sv]
// Lift drive core: motor duties, encoder positioning and sweeper retract pulses.
// Depends on epld_pkg, the channel interfaces in epld_if.sv and epld_step.
//
// Usage:
//   in_ch carries one event per transaction: raise, lower, stop, limit-switch
//   edge or encoder sample. Every accepted transaction yields exactly one
//   result transaction on out_ch with the duties, moving flag, clamped
//   position and the two retract pulses as they stand after the event.
//   cfg_ch writes food_height (Q4 mm); it is always ready and should only be
//   written while no results are pending. The stop threshold derived from it
//   is registered at the write, so the next event may follow right away.
//   out_ch.valid rises in the cycle after acceptance. Throughput is one
//   transaction per cycle while out_ch is ready, set by the single next-state
//   pass of epld_step feeding the result register.
//   When out_ch stalls, the result register holds and in_ch.ready drops until
//   the result is taken; ready returns in the same cycle it is taken.
//   Synchronous active-low reset halts the motor, clears the count and flags,
//   empties the result register and restores the stop threshold for 11.5 mm food.
`include "encoder_positioned_lift_drive_core_macros.svh"

module encoder_positioned_lift_drive_core (
  input  logic              clk,
  input  logic              rst_n,
  epld_in_if.sink           in_ch,
  epld_out_if.source        out_ch,
  epld_cfg_if.sink          cfg_ch
);
  import epld_pkg::*;

  epld_state_t             state_r;
  epld_state_t             state_nxt;
  epld_item_t              item;
  epld_res_t               res_nxt;
  epld_res_t               out_r;
  logic                    out_valid_r;
  logic signed [THR_W-1:0] lower_thr_r;
  logic                    in_fire;

  // Input transaction packing and handshake.
  assign item = '{operation:     in_ch.operation,
                  duty:          in_ch.duty,
                  retract_after: in_ch.retract_after,
                  partial_raise: in_ch.partial_raise,
                  switch_level:  in_ch.switch_level,
                  enc_a:         in_ch.enc_a,
                  enc_b:         in_ch.enc_b};
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  epld_step u_step (
    .state     (state_r),
    .item      (item),
    .lower_thr (lower_thr_r),
    .state_nxt (state_nxt),
    .res       (res_nxt)
  );

  // Stop threshold, recomputed on each configuration write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_thr_r <= LOWER_THR_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      lower_thr_r <= epld_lower_thr(cfg_ch.food_height);
    end
  end

  // Drive state updates on every accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{count: '0, last_phase: 2'b00, going_up: 1'b0, halted: 1'b1,
                   retract_on_lower: 1'b0, retract_on_raise: 1'b0,
                   partial_armed: 1'b0, up_duty: '0, down_duty: '0};
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.up_drive      = out_r.up_drive;
  assign out_ch.down_drive    = out_r.down_drive;
  assign out_ch.moving        = out_r.moving;
  assign out_ch.position      = out_r.position;
  assign out_ch.sweep_serving = out_r.sweep_serving;
  assign out_ch.sweep_fixed   = out_r.sweep_fixed;

  // Every accepted transaction leaves a result waiting.
  `EPLD_ASSERT_NXT(a_accept_gives_result, in_fire, out_valid_r,
                   "accepted transaction produced no result")
  // A lower command shows a moving platform at zero with the up side off.
  `EPLD_ASSERT_NXT(a_lower_result, in_fire && (in_ch.operation == OP_LOWER),
                   out_ch.moving && (out_ch.position == '0) && (out_ch.up_drive == '0),
                   "lower command result is wrong")
  // A retract pulse only appears with a halted platform.
  `EPLD_ASSERT_IMP(a_pulse_halted, out_valid_r && (out_r.sweep_serving || out_r.sweep_fixed),
                   !out_r.moving, "retract pulse while moving")
  // A halted drive has both motor outputs off.
  `EPLD_ASSERT_IMP(a_halted_idle, state_r.halted,
                   (state_r.up_duty == '0) && (state_r.down_duty == '0),
                   "motor driven while halted")
  // Upward duty only while raising.
  `EPLD_ASSERT_IMP(a_up_means_raise, state_r.up_duty != '0, state_r.going_up,
                   "up duty without a raise in progress")

endmodule
